@@ hdl/booth_radix2_multiplier_defines.svh @@
`ifndef BOOTH_RADIX2_MULTIPLIER_DEFINES_SVH
`define BOOTH_RADIX2_MULTIPLIER_DEFINES_SVH

// same-cycle implication, checking paused while rst_sig is high
`define BMUL_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checking paused while rst_sig is high
`define BMUL_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bmul_pkg.sv @@
`timescale 1ns / 1ps

package bmul_pkg;

  localparam int OPERAND_WIDTH = 32;

  // booth recode pair {current bit, previous bit}
  localparam logic [1:0] BOOTH_ADD = 2'b01;
  localparam logic [1:0] BOOTH_SUB = 2'b10;

  typedef struct packed {
    logic [OPERAND_WIDTH:0]   upper;
    logic [OPERAND_WIDTH-1:0] lower;
    logic                     prev;
    logic [OPERAND_WIDTH-1:0] mcand;
  } booth_state_t;

endpackage

@@ hdl/bmul_ifs.sv @@
`timescale 1ns / 1ps

interface bmul_operand_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] multiplier_in;
  logic signed [31:0] multiplicand_in;

  modport source (output valid, output multiplier_in, output multiplicand_in, input ready);
  modport sink (input valid, input multiplier_in, input multiplicand_in, output ready);
endinterface

interface bmul_product_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] product_out;

  modport source (output valid, output product_out, input ready);
  modport sink (input valid, input product_out, output ready);
endinterface

@@ hdl/bmul_stage.sv @@
`timescale 1ns / 1ps

module bmul_stage
  import bmul_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  booth_state_t in_state,
  output logic         out_valid,
  input  logic         out_ready,
  output booth_state_t out_state
);

  logic [OPERAND_WIDTH+1:0] upper_ext;
  logic [OPERAND_WIDTH+1:0] mcand_ext;
  logic [OPERAND_WIDTH+1:0] sum;
  booth_state_t             state_next;

  assign upper_ext = {in_state.upper[OPERAND_WIDTH], in_state.upper};
  assign mcand_ext = {{2{in_state.mcand[OPERAND_WIDTH-1]}}, in_state.mcand};

  always_comb begin
    case ({in_state.lower[0], in_state.prev})
      BOOTH_ADD: sum = upper_ext + mcand_ext;
      BOOTH_SUB: sum = upper_ext - mcand_ext;
      default:   sum = upper_ext;
    endcase
  end

  // arithmetic right shift of the whole {upper, lower} word
  always_comb begin
    state_next.upper = sum[OPERAND_WIDTH+1:1];
    state_next.lower = {sum[0], in_state.lower[OPERAND_WIDTH-1:1]};
    state_next.prev  = in_state.lower[0];
    state_next.mcand = in_state.mcand;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_state <= state_next;
    end
  end

endmodule

@@ hdl/booth_radix2_multiplier.sv @@
`timescale 1ns / 1ps
// booth_radix2_multiplier: signed 32 x 32 -> 64 bit multiplier, radix-2 booth
//
// operand channel (sink): multiplier_in and multiplicand_in, one word per
//   valid/ready handshake; product channel (source): product_out, same handshake
// pipeline: one booth recode step per pipeline stage, 32 stages; an accepted
//   operand word passes through the stage registers in order, and the last
//   stage register drives the product channel directly
// throughput: one word per cycle unless the product side stalls, set by the single-step stages
// stalls: each stage holds its word while the next one is full and stalled;
//   empty stages keep filling, so bubbles close up and the operand side is
//   held off only once every stage holds a word
// reset (rst, synchronous, active high): all stage valid bits clear, the
//   pipeline comes out of reset empty with operand ready high
// operands are two's complement; only the low OPERAND_WIDTH bits are used
`include "booth_radix2_multiplier_defines.svh"

module booth_radix2_multiplier
  import bmul_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  bmul_operand_if.sink    operand,
  bmul_product_if.source  product
);

  // index 0 is the operand channel, index OPERAND_WIDTH is the product register
  logic [OPERAND_WIDTH:0] stage_valid;
  logic [OPERAND_WIDTH:0] stage_ready;
  booth_state_t           stage_state [OPERAND_WIDTH+1];

  logic [2*OPERAND_WIDTH:0] full_product;

  // load: upper partial product clear, lower holds the multiplier, prev bit 0
  always_comb begin
    stage_state[0].upper = '0;
    stage_state[0].lower = operand.multiplier_in[OPERAND_WIDTH-1:0];
    stage_state[0].prev  = 1'b0;
    stage_state[0].mcand = operand.multiplicand_in[OPERAND_WIDTH-1:0];
  end

  assign stage_valid[0]             = operand.valid;
  assign operand.ready              = stage_ready[0];
  assign stage_ready[OPERAND_WIDTH] = product.ready;

  // one recode step per stage
  for (genvar i = 0; i < OPERAND_WIDTH; i++) begin : g_step
    bmul_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_state  (stage_state[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_state (stage_state[i+1])
    );
  end

  // {upper, lower} after the last shift is the product, truncated to 64 bits
  assign full_product = {stage_state[OPERAND_WIDTH].upper, stage_state[OPERAND_WIDTH].lower};
  assign product.product_out = 64'($signed(full_product));
  assign product.valid       = stage_valid[OPERAND_WIDTH];

  // a full pipeline stalled at the output must hold off the operand side
  `BMUL_ASSERT_NOW(a_full_blocks_input, clk, rst,
    (&stage_valid[OPERAND_WIDTH:1]) && !product.ready, !operand.ready,
    "operand accepted while pipeline full and stalled")

  // an accepted operand word lands in the first stage
  `BMUL_ASSERT_NEXT(a_accept_loads_stage, clk, rst,
    operand.valid && operand.ready, stage_valid[1],
    "accepted operand word missing from first stage")

  // pipeline comes out of reset empty
  `BMUL_ASSERT_NEXT(a_reset_empty, clk, 1'b0,
    rst, (stage_valid[OPERAND_WIDTH:1] == '0),
    "stage valid bits set after reset")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench
  import bmul_pkg::*;
;

  localparam int PIPE_DEPTH = 32;  // recode stages

  logic clk;
  logic rst;

  bmul_operand_if operand_ch ();
  bmul_product_if product_ch ();

  booth_radix2_multiplier dut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand_ch),
    .product (product_ch)
  );

  // products still owed by the block, oldest first
  logic [63:0] pending_products[$];
  int          mismatches = 0;

  // idle knobs in percent, changed per test phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // long receiver hold-off, counted down by the receiver process
  int hold_left      = 0;

  always #10 clk = ~clk;

  // predicted product: radix-2 booth recode over OPERAND_WIDTH steps,
  // upper partial product kept sign-extended in a 64-bit vector
  function automatic logic [63:0] booth_product(logic [31:0] mplier, logic [31:0] mcand);
    logic [63:0] mask;
    logic [63:0] addend;
    logic [63:0] upper;
    logic [63:0] lower;
    logic        prev;
    logic        cur;
    mask   = (64'd1 << OPERAND_WIDTH) - 64'd1;
    addend = {32'd0, mcand} & mask;
    if (addend[OPERAND_WIDTH-1]) begin
      addend = addend | ~mask;
    end
    lower = {32'd0, mplier} & mask;
    upper = 64'd0;
    prev  = 1'b0;
    for (int step = 0; step < OPERAND_WIDTH; step++) begin
      cur = lower[0];
      case ({cur, prev})
        BOOTH_ADD: upper = upper + addend;
        BOOTH_SUB: upper = upper - addend;
        default: ;
      endcase
      prev  = cur;
      lower = (lower >> 1) | ({63'd0, upper[0]} << (OPERAND_WIDTH - 1));
      upper = {upper[63], upper[63:1]};
    end
    return (upper << OPERAND_WIDTH) | (lower & mask);
  endfunction

  // operand mix: extremes, small magnitudes of both signs, walking bits, full random
  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    case ($urandom_range(0, 6))
      0: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      1: v = $urandom_range(0, 255);
      2: v = -$urandom_range(1, 256);
      3: begin
        v = 32'd1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1)) begin
          v = ~v;
        end
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // offer one word, hold it until accepted, then log the predicted product
  task automatic send_word(logic [31:0] mplier, logic [31:0] mcand);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      operand_ch.valid <= 1'b0;
      @(posedge clk);
    end
    operand_ch.valid           <= 1'b1;
    operand_ch.multiplier_in   <= mplier;
    operand_ch.multiplicand_in <= mcand;
    do begin
      @(posedge clk);
    end while (!operand_ch.ready);
    pending_products.push_back(booth_product(mplier, mcand));
  endtask

  // stop offering and wait for every owed product, plus a settling margin
  task automatic wait_drain();
    operand_ch.valid <= 1'b0;
    while (pending_products.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_DEPTH + 8) @(posedge clk);
  endtask

  // corner operand pairs, each booth action with both signs
  task automatic test_directed();
    logic [31:0] corner_a[$];
    logic [31:0] corner_b[$];
    corner_a = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0000,
                 32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff, 32'h0000_0001,
                 32'h8000_0001, 32'h0000_ffff, 32'hffff_0000, 32'h1234_5678,
                 32'h0000_0002, 32'hffff_fffe, 32'h7fff_ffff, 32'h8000_0000};
    corner_b = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000,
                 32'haaaa_aaaa, 32'h5555_5555, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0001, 32'hffff_0000, 32'h0000_ffff, 32'hedcb_a988,
                 32'hffff_fffe, 32'h0000_0002, 32'h0000_0000, 32'h0000_0001};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (corner_a[i]) begin
      send_word(corner_a[i], corner_b[i]);
    end
    wait_drain();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      send_word(rand_operand(), rand_operand());
    end
    wait_drain();
  endtask

  // receiver holds off long enough for all stages to fill and the operand
  // side to stall, while words keep coming back to back
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 4 * PIPE_DEPTH;
    repeat (2 * PIPE_DEPTH) begin
      send_word(rand_operand(), rand_operand());
    end
    wait_drain();
  endtask

  // receiver: random stalls by phase, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      product_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      product_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // compare each accepted product with the oldest prediction
  always @(posedge clk) begin
    if (!rst && product_ch.valid && product_ch.ready) begin
      if (pending_products.size() == 0) begin
        $display("%0t: unexpected product, expected none, got %h",
                 $time, product_ch.product_out);
        mismatches++;
      end else if (product_ch.product_out !== pending_products[0]) begin
        $display("%0t: product mismatch, expected %h, got %h",
                 $time, pending_products[0], product_ch.product_out);
        mismatches++;
        void'(pending_products.pop_front());
      end else begin
        void'(pending_products.pop_front());
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("FAIL booth_radix2_multiplier");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst <= 1'b1;
    operand_ch.valid           <= 1'b0;
    operand_ch.multiplier_in   <= '0;
    operand_ch.multiplicand_in <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random(220, 0, 0);
    test_random(220, 88, 0);
    test_random(220, 0, 88);
    test_random(210, 25, 25);

    if (pending_products.size() != 0) begin
      $display("%0t: %0d products never arrived, expected %h first, got none",
               $time, pending_products.size(), pending_products[0]);
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS booth_radix2_multiplier");
    end else begin
      $display("FAIL booth_radix2_multiplier");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/bmul_pkg.sv
hdl/bmul_ifs.sv
hdl/bmul_stage.sv
hdl/booth_radix2_multiplier.sv
test/testbench.sv
